FILE: design/idfl_pkg.sv
// Shared types, codes and constants of the id range free list unit.
package idfl_pkg;

  // Field widths
  localparam int unsigned ID_W    = 31;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOT_W   = 32;

  // Highest id; it is never stored
  localparam logic [ID_W-1:0] ID_TOP = {ID_W{1'b1}};

  // Parameter defaults
  localparam int unsigned DEF_MAX_RANGES  = 16;
  localparam int unsigned DEF_MAX_REQUEST = 64;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_RECYCLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_CLAMP = 2'd3;

endpackage

FILE: design/id_range_free_list_unit.sv
// Top level of the id range free list unit: range store and its sequencer.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-------------------------------------
//  command | in        | start_i, busy_o                | kind_i first_id_i count_i consecutive_i
//  result  | out       | result_valid_o (one-cycle strobe) | id_out_o id_valid_o last_result_o
//          |           |                                | status_o free_total_o
//
// A transaction is taken when start_i is high and busy_o is low. A single
// read/write port on the range store plus one adder/comparator are stepped by
// the sequencer, one store entry per cycle. Recycle: scan, shift-insert, merge
// pass, plus an undo shift when the store overflows. Allocate: optional scan,
// one id per cycle, then a compaction pass. Query and trivial cases answer
// straight from the idle state. Reset empties the store at once. Results
// cannot be stalled; each one is on the ports for one cycle.
module id_range_free_list_unit
  import idfl_pkg::*;
#(
  parameter int unsigned MAX_RANGES  = DEF_MAX_RANGES,
  parameter int unsigned MAX_REQUEST = DEF_MAX_REQUEST
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [ID_W-1:0]    first_id_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic               consecutive_i,
  output logic               result_valid_o,
  output logic [ID_W-1:0]    id_out_o,
  output logic               id_valid_o,
  output logic               last_result_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [TOT_W-1:0]   free_total_o
);

  localparam int unsigned DEPTH = MAX_RANGES + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 2);
  localparam int unsigned REQ_W = $clog2(MAX_REQUEST + 1);
  localparam int unsigned SUM_W = ID_W + $clog2(DEPTH);

  localparam logic [CNT_W-1:0] MAX_R   = CNT_W'(MAX_RANGES);
  localparam logic [REQ_W-1:0] MAX_Q   = REQ_W'(MAX_REQUEST);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RSCAN = 4'd1;
  localparam logic [3:0] S_RSHFT = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_FLUSH = 4'd4;
  localparam logic [3:0] S_UNDO  = 4'd5;
  localparam logic [3:0] S_ASCAN = 4'd6;
  localparam logic [3:0] S_AEMIT = 4'd7;

  // Range store
  logic [ID_W-1:0] start_mem [DEPTH];
  logic [ID_W-1:0] len_mem   [DEPTH];

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] rc_q, rc_d;       // stored ranges
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] pos_q, pos_d;     // insert position
  logic [CNT_W-1:0] w_q, w_d;         // compaction write index
  logic [CNT_W-1:0] n_q, n_d;         // entries in the pass
  logic             drop_q, drop_d;   // compaction drops empties, no merge
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [ID_W-1:0]  s_q, s_d;
  logic [COUNT_W-1:0] ln_q, ln_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [REQ_W-1:0] rem_q, rem_d;
  logic             clamp_q, clamp_d;
  logic [ID_W-1:0]  hs_q, hs_d;
  logic [ID_W-1:0]  hl_q, hl_d;
  logic [ID_W:0]    pe_q, pe_d;       // end of previous entry, one bit wider

  // Result register
  logic              rv_q;
  logic [ID_W-1:0]   rid_q;
  logic              ridv_q, rlast_q;
  logic [STAT_W-1:0] rst_q;
  logic [TOT_W-1:0]  rtot_q;

  logic              emit;
  logic [ID_W-1:0]   e_id;
  logic              e_idv, e_last;
  logic [STAT_W-1:0] e_st;
  logic [TOT_W-1:0]  e_tot;

  // Store port
  logic [CNT_W-1:0] rd_idx;
  logic [ID_W-1:0]  rd_s, rd_l;
  logic             we;
  logic [CNT_W-1:0] wa;
  logic [ID_W-1:0]  ws, wl;

  // Saturate the running sum to the result width
  function automatic logic [TOT_W-1:0] sat(input logic [SUM_W-1:0] v);
    logic [TOT_W-1:0] r;
    r = (v > SUM_W'({TOT_W{1'b1}})) ? {TOT_W{1'b1}} : TOT_W'(v);
    return r;
  endfunction

  logic [ID_W-1:0]    avail;
  logic [COUNT_W-1:0] cut_len;
  logic [REQ_W-1:0]   req_in;
  logic               clamp_in;
  logic [REQ_W-1:0]   given;
  logic [ID_W:0]      rd_end;
  logic [CNT_W-1:0]   nf;

  assign rd_s   = start_mem[rd_idx[IDX_W-1:0]];
  assign rd_l   = len_mem[rd_idx[IDX_W-1:0]];
  assign rd_end = {1'b0, rd_s} + {1'b0, rd_l};

  // Command decode helpers
  assign avail    = ID_TOP - first_id_i;
  assign cut_len  = ({{(ID_W-COUNT_W){1'b0}}, count_i} > avail) ? avail[COUNT_W-1:0]
                                                                 : count_i;
  assign clamp_in = ({{REQ_W{1'b0}}, count_i} > {{COUNT_W{1'b0}}, MAX_Q});
  assign req_in   = clamp_in ? MAX_Q : count_i[REQ_W-1:0];
  assign given    = (sum_q < SUM_W'(req_in)) ? sum_q[REQ_W-1:0] : req_in;
  assign nf       = w_q + CNT_W'(1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    rc_d    = rc_q;
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    w_d     = w_q;
    n_d     = n_q;
    drop_d  = drop_q;
    sum_d   = sum_q;
    s_d     = s_q;
    ln_d    = ln_q;
    req_d   = req_q;
    rem_d   = rem_q;
    clamp_d = clamp_q;
    hs_d    = hs_q;
    hl_d    = hl_q;
    pe_d    = pe_q;
    rd_idx  = ptr_q;
    we      = 1'b0;
    wa      = ptr_q;
    ws      = rd_s;
    wl      = rd_l;
    emit    = 1'b0;
    e_id    = '0;
    e_idv   = 1'b0;
    e_last  = 1'b1;
    e_st    = STAT_OK;
    e_tot   = sat(sum_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          s_d     = first_id_i;
          ln_d    = cut_len;
          req_d   = req_in;
          clamp_d = clamp_in;
          ptr_d   = '0;
          if (kind_i == KIND_RECYCLE) begin
            if (cut_len == '0) emit = 1'b1;
            else state_d = S_RSCAN;
          end else if (kind_i == KIND_ALLOCATE) begin
            if (req_in == '0) begin
              emit = 1'b1;
            end else if (consecutive_i) begin
              state_d = S_ASCAN;
            end else if (given == '0) begin
              emit = 1'b1;
              e_st = STAT_SHORT;
            end else begin
              rem_d   = given;
              sum_d   = sum_q - SUM_W'(given);
              clamp_d = clamp_in;
              req_d   = (given < req_in) ? '0 : req_in;  // zero marks a shortage
              state_d = S_AEMIT;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end

      // Find the first stored range that starts above the run
      S_RSCAN: begin
        if (ptr_q == rc_q || rd_s > s_q) begin
          pos_d   = ptr_q;
          ptr_d   = rc_q;
          state_d = S_RSHFT;
        end else begin
          ptr_d = ptr_q + CNT_W'(1);
        end
      end

      // Open a slot at the insert position, top entry first
      S_RSHFT: begin
        if (ptr_q == pos_q) begin
          we      = 1'b1;
          ws      = s_q;
          wl      = ID_W'(ln_q);
          ptr_d   = '0;
          w_d     = '0;
          n_d     = rc_q + CNT_W'(1);
          drop_d  = 1'b0;
          state_d = S_CMP;
        end else begin
          rd_idx = ptr_q - CNT_W'(1);
          we     = 1'b1;
          ptr_d  = ptr_q - CNT_W'(1);
        end
      end

      // Compaction pass: merge adjacent ranges, or drop emptied ones
      S_CMP: begin
        wa = w_q;
        if (drop_q) begin
          if (rd_l != '0) begin
            we  = 1'b1;
            w_d = w_q + CNT_W'(1);
          end
          if (ptr_q == n_q - CNT_W'(1)) begin
            rc_d    = (rd_l != '0) ? w_q + CNT_W'(1) : w_q;
            state_d = S_IDLE;
          end
        end else begin
          if (ptr_q == '0) begin
            hs_d = rd_s;
            hl_d = rd_l;
          end else if ({1'b0, rd_s} == pe_q) begin
            hl_d = hl_q + rd_l;
          end else begin
            we   = 1'b1;
            ws   = hs_q;
            wl   = hl_q;
            w_d  = w_q + CNT_W'(1);
            hs_d = rd_s;
            hl_d = rd_l;
          end
          pe_d = rd_end;
          if (ptr_q == n_q - CNT_W'(1)) state_d = S_FLUSH;
        end
        ptr_d = ptr_q + CNT_W'(1);
      end

      // Write the last merged range and check for overflow
      S_FLUSH: begin
        we = 1'b1;
        wa = w_q;
        ws = hs_q;
        wl = hl_q;
        if (nf > MAX_R) begin
          ptr_d   = pos_q;
          state_d = S_UNDO;
        end else begin
          rc_d    = nf;
          sum_d   = sum_q + SUM_W'(ln_q);
          emit    = 1'b1;
          e_tot   = sat(sum_q + SUM_W'(ln_q));
          state_d = S_IDLE;
        end
      end

      // Store full: close the slot again
      S_UNDO: begin
        if (ptr_q == rc_q) begin
          emit    = 1'b1;
          e_st    = STAT_FULL;
          state_d = S_IDLE;
        end else begin
          rd_idx = ptr_q + CNT_W'(1);
          we     = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
        end
      end

      // Find the first range long enough for a consecutive request
      S_ASCAN: begin
        if (ptr_q == rc_q) begin
          emit    = 1'b1;
          e_st    = STAT_SHORT;
          state_d = S_IDLE;
        end else if (rd_l >= ID_W'(req_q)) begin
          rem_d   = req_q;
          sum_d   = sum_q - SUM_W'(req_q);
          state_d = S_AEMIT;
        end else begin
          ptr_d = ptr_q + CNT_W'(1);
        end
      end

      // Hand out one id per cycle from the current range
      S_AEMIT: begin
        we     = 1'b1;
        ws     = rd_s + ID_W'(1);
        wl     = rd_l - ID_W'(1);
        emit   = 1'b1;
        e_id   = rd_s;
        e_idv  = 1'b1;
        e_last = (rem_q == REQ_W'(1));
        e_st   = (req_q == '0) ? STAT_SHORT : (clamp_q ? STAT_CLAMP : STAT_OK);
        rem_d  = rem_q - REQ_W'(1);
        if (rd_l == ID_W'(1)) ptr_d = ptr_q + CNT_W'(1);
        if (rem_q == REQ_W'(1)) begin
          ptr_d   = '0;
          w_d     = '0;
          n_d     = rc_q;
          drop_d  = 1'b1;
          state_d = S_CMP;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rc_q    <= '0;
      sum_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      sum_q   <= sum_d;
      rv_q    <= emit;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    w_q     <= w_d;
    n_q     <= n_d;
    drop_q  <= drop_d;
    s_q     <= s_d;
    ln_q    <= ln_d;
    req_q   <= req_d;
    rem_q   <= rem_d;
    clamp_q <= clamp_d;
    hs_q    <= hs_d;
    hl_q    <= hl_d;
    pe_q    <= pe_d;
    if (emit) begin
      rid_q   <= e_id;
      ridv_q  <= e_idv;
      rlast_q <= e_last;
      rst_q   <= e_st;
      rtot_q  <= e_tot;
    end
  end

  // Range store write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[wa[IDX_W-1:0]] <= ws;
      len_mem[wa[IDX_W-1:0]]   <= wl;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign id_out_o       = rid_q;
  assign id_valid_o     = ridv_q;
  assign last_result_o  = rlast_q;
  assign status_o       = rst_q;
  assign free_total_o   = rtot_q;

  // Checks
  a_more_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy_o)
    else $error("non-final result while idle");

  a_noid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !id_valid_o |-> last_result_o && (id_out_o == '0))
    else $error("result without id must be the only one");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || result_valid_o)
    else $error("accepted transaction made no progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> rc_q <= MAX_R)
    else $error("range count over limit");

endmodule

FILE: tb/sv/tb_id_range_free_list_unit.sv
// Self-checking testbench of the id range free list unit.
module tb_id_range_free_list_unit
  import idfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NRANGE = DEF_MAX_RANGES;
  localparam int unsigned NREQ   = DEF_MAX_REQUEST;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    first_id;
    logic [COUNT_W-1:0] count;
    logic               consecutive;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              id_valid;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [TOT_W-1:0]  total;
  } res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [KIND_W-1:0]  kind_i = '0;
  logic [ID_W-1:0]    first_id_i = '0;
  logic [COUNT_W-1:0] count_i = '0;
  logic               consecutive_i = 1'b0;
  logic               result_valid_o;
  logic [ID_W-1:0]    id_out_o;
  logic               id_valid_o;
  logic               last_result_o;
  logic [STAT_W-1:0]  status_o;
  logic [TOT_W-1:0]   free_total_o;

  id_range_free_list_unit u_top (.*);

  // Predictor state: sorted free ranges
  logic [ID_W-1:0] free_base [NRANGE];
  logic [ID_W-1:0] free_len  [NRANGE];
  int unsigned     free_cnt;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  int   sent = 0;
  int   got = 0;
  int   idle_pct = 26;
  int   stall_cnt = 0;
  bit   stim_done = 0;

  function automatic logic [TOT_W-1:0] sum_free();
    longint unsigned s;
    s = 0;
    for (int i = 0; i < free_cnt; i++) s += 64'(free_len[i]);
    return (s > 64'hFFFF_FFFF) ? '1 : s[TOT_W-1:0];
  endfunction

  function automatic void compact_ranges();
    int unsigned j;
    j = 0;
    for (int i = 0; i < free_cnt; i++)
      if (free_len[i] != 0) begin
        free_base[j] = free_base[i];
        free_len[j]  = free_len[i];
        j++;
      end
    free_cnt = j;
  endfunction

  // Insert a run sorted after equal starts, then join adjacent neighbors
  function automatic logic [STAT_W-1:0] return_run(logic [ID_W-1:0] base,
                                                   logic [31:0] len);
    logic [31:0] tb_[NRANGE+1];
    logic [31:0] tl_[NRANGE+1];
    int n;
    bit placed;
    n = 0;
    placed = 0;
    if (len > 32'(ID_TOP) - 32'(base)) len = 32'(ID_TOP) - 32'(base);
    if (len == 0) return STAT_OK;
    for (int i = 0; i < free_cnt; i++) begin
      if (!placed && free_base[i] > base) begin
        tb_[n] = 32'(base); tl_[n] = len; n++; placed = 1;
      end
      tb_[n] = 32'(free_base[i]); tl_[n] = 32'(free_len[i]); n++;
    end
    if (!placed) begin
      tb_[n] = 32'(base); tl_[n] = len; n++;
    end
    for (int i = n - 1; i > 0; i--)
      if (tb_[i] == tb_[i-1] + tl_[i-1]) begin
        tl_[i-1] += tl_[i];
        for (int j = i; j + 1 < n; j++) begin
          tb_[j] = tb_[j+1]; tl_[j] = tl_[j+1];
        end
        n--;
      end
    if (n > NRANGE) return STAT_FULL;
    for (int i = 0; i < n; i++) begin
      free_base[i] = tb_[i][ID_W-1:0];
      free_len[i]  = tl_[i][ID_W-1:0];
    end
    free_cnt = n;
    return STAT_OK;
  endfunction

  // Work out the results of one accepted transaction
  function automatic void predict_results(cmd_t c);
    logic [ID_W-1:0]   ids[$];
    logic [STAT_W-1:0] st;
    logic [TOT_W-1:0]  tot;
    int unsigned       req;
    bit                clamped;
    int                hit;
    res_t              r;
    st = STAT_OK;
    clamped = 0;
    if (c.kind == KIND_RECYCLE) begin
      st = return_run(c.first_id, 32'(c.count));
    end else if (c.kind == KIND_ALLOCATE) begin
      req = 32'(c.count);
      if (req > NREQ) begin
        req = NREQ; clamped = 1;
      end
      if (req > 0 && c.consecutive) begin
        hit = -1;
        for (int i = 0; i < free_cnt; i++)
          if (hit < 0 && free_len[i] >= req) hit = i;
        if (hit >= 0) begin
          for (int k = 0; k < req; k++) ids.push_back(free_base[hit] + ID_W'(k));
          free_base[hit] += ID_W'(req);
          free_len[hit]  -= ID_W'(req);
          compact_ranges();
        end
      end else if (req > 0) begin
        for (int i = 0; i < free_cnt && ids.size() < req; i++)
          while (free_len[i] > 0 && ids.size() < req) begin
            ids.push_back(free_base[i]);
            free_base[i]++;
            free_len[i]--;
          end
        compact_ranges();
      end
      if (ids.size() < req) st = STAT_SHORT;
      else if (clamped) st = STAT_CLAMP;
    end
    tot = sum_free();
    if (ids.size() == 0) begin
      r = '{id: '0, id_valid: 1'b0, last: 1'b1, status: st, total: tot};
      expected_results.push_back(r);
    end else begin
      foreach (ids[k]) begin
        r = '{id: ids[k], id_valid: 1'b1, last: (k == ids.size() - 1),
              status: st, total: tot};
        expected_results.push_back(r);
      end
    end
  endfunction

  // Clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents queued commands, random gaps between transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_results({kind_i, first_id_i, count_i, consecutive_i});
        sent++;
      end
      if ((!start_i || !busy_o) ) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          start_i <= 1'b1;
          kind_i <= c.kind;
          first_id_i <= c.first_id;
          count_i <= c.count;
          consecutive_i <= c.consecutive;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result strobe with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        res_t a, e;
        a = '{id: id_out_o, id_valid: id_valid_o, last: last_result_o,
              status: status_o, total: free_total_o};
        got++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, a);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (a.id !== e.id)
            $display("%0t: id_out expected %0d actual %0d", $time, e.id, a.id);
          if (a.id_valid !== e.id_valid)
            $display("%0t: id_valid expected %0d actual %0d", $time, e.id_valid, a.id_valid);
          if (a.last !== e.last)
            $display("%0t: last_result expected %0d actual %0d", $time, e.last, a.last);
          if (a.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
          if (a.total !== e.total)
            $display("%0t: free_total expected %0d actual %0d", $time, e.total, a.total);
          if (a !== e) errors++;
        end
      end
      // Watchdog on lack of progress
      if (result_valid_o || (start_i && !busy_o) || stim_done) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic cmd_t mk(logic [KIND_W-1:0] k, logic [ID_W-1:0] f,
                              logic [COUNT_W-1:0] n, logic cs);
    cmd_t c;
    c = '{kind: k, first_id: f, count: n, consecutive: cs};
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    int unsigned sel;
    logic [ID_W-1:0] f;
    logic [COUNT_W-1:0] n;
    sel = $urandom_range(99);
    // Most runs land in a small window so they join and split often
    if ($urandom_range(9) < 8) f = ID_W'($urandom_range(600));
    else f = ID_W'($urandom);
    case ($urandom_range(3))
      0: n = COUNT_W'($urandom);
      default: n = COUNT_W'($urandom_range(40));
    endcase
    if (sel < 45) return mk(KIND_RECYCLE, f, n, 1'($urandom_range(1)));
    if (sel < 90) return mk(KIND_ALLOCATE, ID_W'($urandom),
                            ($urandom_range(7) == 0) ? n : COUNT_W'($urandom_range(70)),
                            1'($urandom_range(1)));
    return mk(KIND_QUERY + KIND_W'(sel % 2), ID_W'($urandom), COUNT_W'($urandom),
              1'($urandom_range(1)));
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Stimulus: directed corner cases, then three random phases
  initial begin
    wait (rst_ni);
    pending_cmds.push_back(mk(KIND_QUERY, '0, '0, 1'b0));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd5, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'd100, 16'd0, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'd100, 16'd10, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'd110, 16'd5, 1'b1));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'd90, 16'd10, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'd100, 16'd3, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, ID_TOP - 31'd3, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, ID_TOP, 16'd7, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'h2AAA_AAAA, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk(KIND_RECYCLE, 31'h5555_5555, 16'h5555, 1'b1));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '1, 16'd0, 1'b1));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd64, 1'b1));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd25, 1'b0));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd65, 1'b1));
    pending_cmds.push_back(mk(KIND_QUERY + 2'd1, '1, '1, 1'b1));
    // Fill the store past its limit with isolated runs
    for (int i = 0; i < 18; i++)
      pending_cmds.push_back(mk(KIND_RECYCLE, ID_W'(1000 + 4 * i), 16'd1, 1'b0));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd2, 1'b1));
    pending_cmds.push_back(mk(KIND_ALLOCATE, '0, 16'd64, 1'b0));
    drain();
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 26 : (p == 1) ? 60 : 0;
      for (int i = 0; i < 111; i++) pending_cmds.push_back(rand_cmd());
      drain();
    end
    stim_done = 1;
    $display("Ran %0d transactions, checked %0d results", sent, got);
    $display("covered recycle/join/overflow, allocate plain/consecutive/clamp, query");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
